@@ sv/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the 3x3 edge-clipped box blur.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W      = 11;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int SUM_W      = 12;
  localparam int RCP_W      = 14;
  localparam int RCP_SH     = 15;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  localparam logic [DIM_W-1:0] CNT_TOP       = '1;
  localparam logic [DIM_W-1:0] WIDTH_RESET   = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET  = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MIN       = DIM_W'(2);
  localparam logic [DIM_W-1:0] WIDTH_TOP     = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_TOP    = DIM_W'(MAX_HEIGHT);

  // reciprocals scaled by 2^RCP_SH, exact for sums below 2^13
  localparam logic [RCP_W-1:0] RCP_9 = RCP_W'(3641);
  localparam logic [RCP_W-1:0] RCP_6 = RCP_W'(5462);
  localparam logic [RCP_W-1:0] RCP_4 = RCP_W'(8192);

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_DRAIN = 1'b1
  } func_e;

  // one classified word from the front end
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic             emit;
    logic             post;
    logic             clip_top;
    logic             clip_bot;
    logic             clip_left;
    logic             last;
  } job_t;

  function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] p, input int k);
    chan = p[CH_W*k +: CH_W];
  endfunction

endpackage

@@ sv/box_blur_3x3_edge_clipped.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped
// 3x3 box blur on a raster RGB stream, neighbourhood clipped to the frame.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one result per clock when both sides
// keep up. A result belongs to the pixel one row and one column behind the
// input, so frame_width + 1 drain words flush the end of a frame; the
// result for the bottom right pixel carries frame_last. Each channel is the
// mean over 9, 6 or 4 pixels, rounded half up. The two line stores are
// single-write, single-read memories touched once per word, which is what
// sets the rate of one word per cycle; with no stalls a word passes stage
// one, the queue, the sum and the output registers. The user must set frame
// size through the write port only while idle; nothing here enforces it.
module box_blur_3x3_edge_clipped (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [bbc_pkg::DIM_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [bbc_pkg::CH_W-1:0]  red_in_i,
  input  logic [bbc_pkg::CH_W-1:0]  green_in_i,
  input  logic [bbc_pkg::CH_W-1:0]  blue_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bbc_pkg::CH_W-1:0]  red_out_o,
  output logic [bbc_pkg::CH_W-1:0]  green_out_o,
  output logic [bbc_pkg::CH_W-1:0]  blue_out_o,
  output logic                      frame_last_o
);

  logic                       push, pop, q_valid;
  bbc_pkg::job_t              job_in, job_out;
  logic [bbc_pkg::QCNT_W-1:0] q_level;

  bbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .q_level_i  (q_level),
    .push_o     (push),
    .job_o      (job_in)
  );

  bbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (job_out),
    .level_o (q_level)
  );

  bbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .job_i        (job_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ sv/bbc_ram.sv @@
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bbc_queue.sv @@
// ----------------------------------------------------------------------------
// bbc_queue
// Short queue of classified words between front end and back end.
// ----------------------------------------------------------------------------
module bbc_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  bbc_pkg::job_t              job_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output bbc_pkg::job_t              job_o,
  output logic [bbc_pkg::QCNT_W-1:0] level_o
);

  bbc_pkg::job_t                    buf_q [bbc_pkg::QDEPTH];
  logic [bbc_pkg::QPTR_W-1:0]       wr_q, wr_d;
  logic [bbc_pkg::QPTR_W-1:0]       rd_q, rd_d;
  logic [bbc_pkg::QCNT_W-1:0]       cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + bbc_pkg::QCNT_W'(push_i) - bbc_pkg::QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= job_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign job_o   = buf_q[rd_q];
  assign level_o = cnt_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < bbc_pkg::QCNT_W'(bbc_pkg::QDEPTH))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue underflow");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_q == rd_q)
    else $error("queue pointers out of step");
`endif

endmodule

@@ sv/bbc_front.sv @@
// ----------------------------------------------------------------------------
// bbc_front
// Accepts words, tracks raster position, reads and updates the line stores
// and classifies each word for the back end.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bbc_pkg::DIM_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [bbc_pkg::CH_W-1:0]    red_in_i,
  input  logic [bbc_pkg::CH_W-1:0]    green_in_i,
  input  logic [bbc_pkg::CH_W-1:0]    blue_in_i,
  input  logic [bbc_pkg::QCNT_W-1:0]  q_level_i,
  output logic                        push_o,
  output bbc_pkg::job_t               job_o
);

  logic [bbc_pkg::DIM_W-1:0]  width_q, height_q, w, h;
  logic [bbc_pkg::DIM_W-1:0]  col_q, col_d, row_q, row_d;
  logic [bbc_pkg::DIM_W-1:0]  c0, r0, c_nxt, r_inc0, r_inc1;
  logic [bbc_pkg::ADDR_W-1:0] addr0;
  logic [bbc_pkg::PIX_W-1:0]  pix0;
  logic                       accept, pre, post, byp0;
  logic [bbc_pkg::QCNT_W-1:0] occ;
  bbc_pkg::job_t              job0;

  // stage one: line store data arrives
  logic                       s1_valid_q;
  bbc_pkg::job_t              s1_job_q;
  logic [bbc_pkg::ADDR_W-1:0] s1_addr_q;
  logic                       s1_byp_q;
  logic [bbc_pkg::PIX_W-1:0]  s1_bup_q, s1_bmid_q;
  logic [bbc_pkg::PIX_W-1:0]  up_rd, mid_rd, up_eff, mid_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbc_pkg::WIDTH_RESET;
      height_q <= bbc_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (bbc_pkg::cfg_idx_e'(cfg_idx_i))
        bbc_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        bbc_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w = (width_q < bbc_pkg::DIM_MIN) ? bbc_pkg::DIM_MIN :
        (width_q > bbc_pkg::WIDTH_TOP) ? bbc_pkg::WIDTH_TOP : width_q;
    h = (height_q < bbc_pkg::DIM_MIN) ? bbc_pkg::DIM_MIN :
        (height_q > bbc_pkg::HEIGHT_TOP) ? bbc_pkg::HEIGHT_TOP : height_q;
  end

  assign occ        = q_level_i + bbc_pkg::QCNT_W'(s1_valid_q);
  assign in_stall_o = (occ >= bbc_pkg::QCNT_W'(bbc_pkg::QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    r_inc0 = (row_q == bbc_pkg::CNT_TOP) ? row_q : row_q + 1'b1;
    if (col_q >= w) begin
      c0 = '0;
      r0 = r_inc0;
    end else begin
      c0 = col_q;
      r0 = row_q;
    end
    r_inc1 = (r0 == bbc_pkg::CNT_TOP) ? r0 : r0 + 1'b1;
    addr0  = c0[bbc_pkg::ADDR_W-1:0];
    pix0   = (bbc_pkg::func_e'(func_i) == bbc_pkg::FUNC_PIXEL) ?
             {red_in_i, green_in_i, blue_in_i} : '0;

    pre  = (c0 == '0) && (r0 >= bbc_pkg::DIM_W'(2));
    post = (c0 != '0) && (r0 != '0);

    job0           = '0;
    job0.pix       = pix0;
    job0.emit      = pre || post;
    job0.post      = post;
    // pre: result for the row two above, last column
    // post: result for the row above, previous column
    job0.clip_top  = pre ? (r0 == bbc_pkg::DIM_W'(2)) : (r0 == bbc_pkg::DIM_W'(1));
    job0.clip_bot  = pre ? (r0 >= h + bbc_pkg::DIM_W'(1)) : (r0 >= h);
    job0.clip_left = post && (c0 == bbc_pkg::DIM_W'(1));
    job0.last      = pre && (r0 >= h + bbc_pkg::DIM_W'(1));

    c_nxt = c0 + 1'b1;
    if (job0.last) begin
      col_d = '0;
      row_d = '0;
    end else if (c_nxt >= w) begin
      col_d = '0;
      row_d = r_inc1;
    end else begin
      col_d = c_nxt;
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // same column written by stage one while read here: forward
  assign byp0 = s1_valid_q && (s1_addr_q == addr0);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_job_q  <= job0;
      s1_addr_q <= addr0;
      s1_byp_q  <= byp0;
      s1_bup_q  <= mid_eff;
      s1_bmid_q <= s1_job_q.pix;
    end
  end

  assign up_eff  = s1_byp_q ? s1_bup_q : up_rd;
  assign mid_eff = s1_byp_q ? s1_bmid_q : mid_rd;

  bbc_ram #(.WIDTH(bbc_pkg::PIX_W), .DEPTH(bbc_pkg::MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_eff),
    .re_i    (accept),
    .raddr_i (addr0),
    .rdata_o (up_rd)
  );

  bbc_ram #(.WIDTH(bbc_pkg::PIX_W), .DEPTH(bbc_pkg::MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_job_q.pix),
    .re_i    (accept),
    .raddr_i (addr0),
    .rdata_o (mid_rd)
  );

  always_comb begin
    job_o     = s1_job_q;
    job_o.up  = up_eff;
    job_o.mid = mid_eff;
  end
  assign push_o = s1_valid_q;

endmodule

@@ sv/bbc_back.sv @@
// ----------------------------------------------------------------------------
// bbc_back
// Keeps the 3x3 window, sums the clipped neighbourhood and divides by the
// pixel count with a reciprocal multiply.
// ----------------------------------------------------------------------------
module bbc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  bbc_pkg::job_t            job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [bbc_pkg::CH_W-1:0] red_out_o,
  output logic [bbc_pkg::CH_W-1:0] green_out_o,
  output logic [bbc_pkg::CH_W-1:0] blue_out_o,
  output logic                     frame_last_o
);

  localparam int PROD_W = bbc_pkg::SUM_W + bbc_pkg::RCP_W;

  // window columns: [row][0] = oldest column, [row][1] = middle column
  logic [bbc_pkg::PIX_W-1:0] win_q [3][2];
  logic [bbc_pkg::PIX_W-1:0] ncol [3];

  logic                      b1_valid_q, b1_last_q, b1_ready;
  logic [bbc_pkg::SUM_W-1:0] b1_x_q [3], x_d [3];
  logic [bbc_pkg::RCP_W-1:0] b1_rcp_q, rcp_d;
  logic                      out_valid_q, out_last_q, out_adv;
  logic [bbc_pkg::CH_W-1:0]  out_q [3];
  logic [PROD_W-1:0]         prod [3];
  logic                      rows3, cols3, inc_a;
  logic [bbc_pkg::SUM_W-1:0] half;
  logic [bbc_pkg::SUM_W-1:0] sum;

  assign out_adv  = !out_valid_q || !out_stall_i;
  assign b1_ready = !b1_valid_q || out_adv;
  assign pop_o    = q_valid_i && b1_ready;

  always_comb begin
    ncol[0] = job_i.up;
    ncol[1] = job_i.mid;
    ncol[2] = job_i.pix;
    rows3   = !job_i.clip_top && !job_i.clip_bot;
    cols3   = job_i.post && !job_i.clip_left;
    inc_a   = !job_i.clip_left;
    if (rows3 && cols3) begin
      rcp_d = bbc_pkg::RCP_9;
      half  = bbc_pkg::SUM_W'(4);
    end else if (rows3 || cols3) begin
      rcp_d = bbc_pkg::RCP_6;
      half  = bbc_pkg::SUM_W'(3);
    end else begin
      rcp_d = bbc_pkg::RCP_4;
      half  = bbc_pkg::SUM_W'(2);
    end
    for (int k = 0; k < 3; k++) begin
      sum = half;
      for (int r = 0; r < 3; r++) begin
        if ((r != 0 || !job_i.clip_top) && (r != 2 || !job_i.clip_bot)) begin
          if (inc_a) sum = sum + bbc_pkg::SUM_W'(bbc_pkg::chan(win_q[r][0], k));
          sum = sum + bbc_pkg::SUM_W'(bbc_pkg::chan(win_q[r][1], k));
          if (job_i.post) sum = sum + bbc_pkg::SUM_W'(bbc_pkg::chan(ncol[r], k));
        end
      end
      x_d[k] = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= '0;
        win_q[r][1] <= '0;
      end
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= ncol[r];
        end
      end
      if (b1_ready) begin
        b1_valid_q <= pop_o && job_i.emit;
      end
      if (out_adv) begin
        out_valid_q <= b1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_ready) begin
      b1_x_q    <= x_d;
      b1_rcp_q  <= rcp_d;
      b1_last_q <= job_i.last;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = PROD_W'(b1_x_q[k]) * PROD_W'(b1_rcp_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      for (int k = 0; k < 3; k++) begin
        out_q[k] <= prod[k][bbc_pkg::RCP_SH +: bbc_pkg::CH_W];
      end
      out_last_q <= b1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = out_q[2];
  assign green_out_o  = out_q[1];
  assign blue_out_o   = out_q[0];
  assign frame_last_o = out_last_q;

endmodule

@@ verif/bbc_blur_checker.sv @@
// ----------------------------------------------------------------------------
// bbc_blur_checker
// Watches both channels of the box blur, predicts each blurred pixel and
// compares it, field by field, with what the block gives.
// ----------------------------------------------------------------------------
module bbc_blur_checker
  import bbc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic             func_i,
  input  logic [CH_W-1:0]  red_in_i,
  input  logic [CH_W-1:0]  green_in_i,
  input  logic [CH_W-1:0]  blue_in_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [CH_W-1:0]  red_out_i,
  input  logic [CH_W-1:0]  green_out_i,
  input  logic [CH_W-1:0]  blue_out_i,
  input  logic             frame_last_i,
  output int               fail_cnt_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } blur_pix_t;

  blur_pix_t        blur_q[$];
  logic [DIM_W-1:0] width_reg, height_reg;
  logic [PIX_W-1:0] upper_row[MAX_WIDTH];
  logic [PIX_W-1:0] middle_row[MAX_WIDTH];
  logic [PIX_W-1:0] win[9];   // row*3+col, col 0 oldest
  int               col_in, row_in, col_out, row_out;

  assign pending_o = blur_q.size();

  function automatic int dim_eff(logic [DIM_W-1:0] v, int top);
    if (v < 2) return 2;
    if (v > top) return top;
    return int'(v);
  endfunction

  function automatic logic [CH_W-1:0] chan_mean(int cc, bit ct, bit cb, bit cl, bit cr,
                                                 int sh);
    int r0, r1, c0, c1, sum, n;
    r0 = ct ? 1 : 0;
    r1 = cb ? 1 : 2;
    c0 = cl ? cc : cc - 1;
    c1 = cr ? cc : cc + 1;
    if (c1 > 2) c1 = 2;
    sum = 0;
    for (int r = r0; r <= r1; r++)
      for (int c = c0; c <= c1; c++)
        sum += (win[r*3+c] >> sh) & 8'hFF;
    n = (r1 - r0 + 1) * (c1 - c0 + 1);
    return CH_W'((sum + n/2) / n);
  endfunction

  function automatic blur_pix_t blur_at(int cc, int w, int h);
    blur_pix_t p;
    bit t, b, l, r;
    t = (row_out == 0);
    b = (row_out >= h - 1);
    l = (col_out == 0) || (cc == 0);
    r = (col_out >= w - 1) || (cc == 2);
    p.red   = chan_mean(cc, t, b, l, r, 16);
    p.green = chan_mean(cc, t, b, l, r, 8);
    p.blue  = chan_mean(cc, t, b, l, r, 0);
    p.last  = b && (col_out >= w - 1);
    return p;
  endfunction

  task automatic predict_word(logic fn, logic [PIX_W-1:0] data);
    int w, h, c;
    bit got;
    blur_pix_t p;
    logic [PIX_W-1:0] pix, up, mid;
    w = dim_eff(width_reg, MAX_WIDTH);
    h = dim_eff(height_reg, MAX_HEIGHT);
    pix = (fn == FUNC_DRAIN) ? '0 : data;
    got = 0;
    if (col_in >= w) begin
      col_in = 0;
      if (row_in < CNT_TOP) row_in++;
    end
    c = col_in;
    up = upper_row[c];
    mid = middle_row[c];
    // row start: last pixel of the row two above, from the old window
    if (c == 0 && row_in >= 2) begin
      row_out = row_in - 2;
      col_out = w - 1;
      p = blur_at(2, w, h);
      got = 1;
    end
    win[0] = win[1]; win[1] = win[2]; win[2] = up;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = pix;
    upper_row[c] = mid;
    middle_row[c] = pix;
    if (c >= 1 && row_in >= 1) begin
      row_out = row_in - 1;
      col_out = c - 1;
      p = blur_at(1, w, h);
      got = 1;
    end
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      if (row_in < CNT_TOP) row_in++;
    end
    if (got) begin
      if (p.last) begin
        col_in = 0;
        row_in = 0;
      end
      blur_q.push_back(p);
    end
  endtask

  task automatic check_word();
    blur_pix_t e;
    if (blur_q.size() == 0) begin
      $error("unexpected word: red %0d green %0d blue %0d last %0d",
             red_out_i, green_out_i, blue_out_i, frame_last_i);
      fail_cnt_o++;
      return;
    end
    e = blur_q.pop_front();
    if (red_out_i !== e.red) begin
      $error("red_out: expected %0d, got %0d", e.red, red_out_i);
      fail_cnt_o++;
    end
    if (green_out_i !== e.green) begin
      $error("green_out: expected %0d, got %0d", e.green, green_out_i);
      fail_cnt_o++;
    end
    if (blue_out_i !== e.blue) begin
      $error("blue_out: expected %0d, got %0d", e.blue, blue_out_i);
      fail_cnt_o++;
    end
    if (frame_last_i !== e.last) begin
      $error("frame_last: expected %0d, got %0d", e.last, frame_last_i);
      fail_cnt_o++;
    end
  endtask

  initial fail_cnt_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      for (int i = 0; i < 9; i++) win[i] = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
      blur_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_word();
      if (in_valid_i && !in_stall_i)
        predict_word(func_i, {red_in_i, green_in_i, blue_in_i});
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) width_reg <= cfg_data_i;
        else height_reg <= cfg_data_i;
      end
    end
  end

endmodule

@@ verif/tb_box_blur_3x3_edge_clipped.sv @@
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_clipped
// Stimulus and verdict for the 3x3 edge-clipped box blur.
// ----------------------------------------------------------------------------
// Directed small frames, then random frames of mostly small sizes with one
// tall frame of the largest height, broken frames and stray drain words
// between them. Both sides idle at random; the checker beside the block
// does the rest.
module tb_box_blur_3x3_edge_clipped;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             func_i = FUNC_PIXEL;
  logic [CH_W-1:0]  red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [CH_W-1:0]  red_out_o, green_out_o, blue_out_o;
  logic             frame_last_o;
  int               fail_cnt, pending;
  int               words_sent = 0;
  bit               calm = 0;       // no idling on either side
  bit               hold_req = 0;   // ask the receiver for a long hold-off

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  box_blur_3x3_edge_clipped uut (.*);

  bbc_blur_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .red_in_i, .green_in_i, .blue_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .red_out_i(red_out_o),
    .green_out_i(green_out_o), .blue_out_i(blue_out_o), .frame_last_i(frame_last_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // receiver
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (600) @(negedge clk_i);
        hold_req = 0;
      end
      out_stall_i <= !calm && ($urandom_range(99) < 17);
    end
  end

  task automatic send_word(logic fn, logic [PIX_W-1:0] data);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    {red_in_i, green_in_i, blue_in_i} <= data;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  // both registers, once the block has gone quiet
  task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // w, h are effective sizes; drain words carry random data
  task automatic send_frame(int w, int h, int drain_pct);
    for (int i = 0; i < w*h; i++)
      send_word(($urandom_range(99) < drain_pct) ? FUNC_DRAIN : FUNC_PIXEL,
                PIX_W'($urandom));
    for (int i = 0; i <= w; i++) send_word(FUNC_DRAIN, PIX_W'($urandom));
  endtask

  function automatic int eff(logic [DIM_W-1:0] v, int top);
    return (v < 2) ? 2 : (v > top) ? top : int'(v);
  endfunction

  initial begin
    logic [DIM_W-1:0] w, h;
    int frame_no;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // smallest frame, extreme channel values
    set_frame(2, 2);
    send_word(FUNC_PIXEL, 24'hFFFFFF);
    send_word(FUNC_PIXEL, 24'h000000);
    send_word(FUNC_PIXEL, 24'hAA55AA);
    send_word(FUNC_PIXEL, 24'h55AA55);
    repeat (3) send_word(FUNC_DRAIN, 24'hFFFFFF);
    // all white 3x3 with a drain word in the middle
    set_frame(3, 3);
    for (int i = 0; i < 9; i++)
      send_word((i == 4) ? FUNC_DRAIN : FUNC_PIXEL, 24'hFFFFFF);
    repeat (4) send_word(FUNC_DRAIN, 24'h000000);
    // out of range sizes clamp to 2x2; the extra pixels start a new frame
    set_frame(0, 1);
    repeat (9) send_word(FUNC_PIXEL, PIX_W'($urandom));

    frame_no = 0;
    while (words_sent < 1900) begin
      frame_no++;
      case (frame_no)
        9:  begin w = 11'd2;    h = 11'd2047; end
        default: begin
          w = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(1)) :
                                         DIM_W'($urandom_range(2, 8));
          h = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(1)) :
                                         DIM_W'($urandom_range(2, 6));
        end
      endcase
      set_frame(w, h);
      if (frame_no == 3) hold_req = 1;
      calm = (frame_no >= 6 && frame_no < 10);
      if ($urandom_range(9) < 8 || frame_no < 10) begin
        send_frame(eff(w, MAX_WIDTH), eff(h, MAX_HEIGHT), 5);
        // stray words after the end of a frame begin the next one
        if ($urandom_range(9) == 0)
          repeat ($urandom_range(1, 4)) send_word(FUNC_DRAIN, PIX_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 40))
          send_word(logic'($urandom_range(1)), PIX_W'($urandom));
      end
    end
    calm = 0;

    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
